>>> hw/rtl/i2ah_pkg.sv
`default_nettype none

package i2ah_pkg;

	localparam int VALUE_W   = 32;
	localparam int CHAR_W    = 8;
	localparam int DIGIT_W   = 4;
	localparam int NUM_DIGITS = 10;
	// bits taken into the digit chain per cycle
	localparam int BITS_PER_STEP = 4;
	localparam int CONV_STEPS = VALUE_W / BITS_PER_STEP;
	localparam int STEP_W = $clog2(CONV_STEPS);
	localparam int DIG_IDX_W = $clog2(NUM_DIGITS);
	localparam int HEX_DIGITS = VALUE_W / DIGIT_W;
	// hex output position of the final nibble ("0x" takes positions 0 and 1)
	localparam int HEX_LAST_POS = HEX_DIGITS + 1;
	localparam int POS_W = $clog2(HEX_LAST_POS + 1);

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_A     = 8'h41;

	localparam logic CMD_DEC = 1'b0;
	localparam logic CMD_HEX = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
	} rsp_t;

	typedef struct packed {
		logic clr;
		logic en;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_EMIT
	} st_t;

	// double-dabble correction: add three to a BCD digit of five or more
	function automatic logic [DIGIT_W-1:0] dd_adj(input logic [DIGIT_W-1:0] d);
		logic [DIGIT_W-1:0] r;
		r = (d >= 4'd5) ? d + 4'd3 : d;
		return r;
	endfunction

	function automatic logic [CHAR_W-1:0] hex_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] r;
		if (d < 4'd10) begin
			r = CH_ZERO + CHAR_W'(d);
		end else begin
			r = CH_A + CHAR_W'(d) - 8'd10;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/i2ah_cell.sv
`default_nettype none

module i2ah_cell (
	input  wire logic                                 clk,
	input  wire i2ah_pkg::cell_ctl_t                  ctl,
	input  wire logic [i2ah_pkg::BITS_PER_STEP-1:0]   din,
	output logic      [i2ah_pkg::BITS_PER_STEP-1:0]   dout,
	output logic      [i2ah_pkg::DIGIT_W-1:0]         digit
);

	logic [i2ah_pkg::DIGIT_W-1:0] digit_q;
	logic [i2ah_pkg::DIGIT_W-1:0] digit_nxt;

	// each step: correct, pass the top bit up, take the neighbor's bit in
	always_comb begin
		logic [i2ah_pkg::DIGIT_W-1:0] d;
		logic [i2ah_pkg::DIGIT_W-1:0] a;
		d = digit_q;
		dout = '0;
		for (int j = 0; j < i2ah_pkg::BITS_PER_STEP; j++) begin
			a = i2ah_pkg::dd_adj(d);
			dout[j] = a[i2ah_pkg::DIGIT_W-1];
			d = {a[i2ah_pkg::DIGIT_W-2:0], din[j]};
		end
		digit_nxt = d;
	end

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			digit_q <= '0;
		end else if (ctl.en) begin
			digit_q <= digit_nxt;
		end
	end

	assign digit = digit_q;

endmodule

`default_nettype wire

>>> hw/rtl/int_to_ascii_hex_dec.sv
// Hex mode goes from idle straight to emitting; decimal mode first runs the
// conversion through the 4-bit-per-cycle BCD digit chain, then the digit scan.
// Throughput: one character per cycle while the receiver does not stall; a new
// number is taken only in idle, after the last character of the previous one.
// Reset (arst_n low, asynchronous) returns the controller to idle and empties
// the result register; the digit cells are cleared when each item is taken.
`default_nettype none

module int_to_ascii_hex_dec (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire i2ah_pkg::req_t  req,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output i2ah_pkg::rsp_t       rsp
);

	i2ah_pkg::st_t state_q, state_nxt;

	logic                                   cmd_q;
	logic                                   neg_q;
	logic [i2ah_pkg::VALUE_W-1:0]           mag_q;
	logic [i2ah_pkg::STEP_W-1:0]            step_q;
	logic [i2ah_pkg::POS_W-1:0]             pos_q;
	logic [i2ah_pkg::DIG_IDX_W-1:0]         dig_q;
	logic                                   rsp_valid_q;
	i2ah_pkg::rsp_t                         rsp_q;

	logic                                   req_take;
	logic                                   can_load;
	logic                                   load;
	i2ah_pkg::rsp_t                         load_rsp;
	i2ah_pkg::cell_ctl_t                    cell_ctl;
	logic [i2ah_pkg::DIG_IDX_W-1:0]         top_idx;
	logic [i2ah_pkg::VALUE_W-1:0]           abs_val;
	logic [i2ah_pkg::BITS_PER_STEP-1:0]     feed;

	logic [i2ah_pkg::BITS_PER_STEP-1:0]     chain [i2ah_pkg::NUM_DIGITS+1];
	logic [i2ah_pkg::DIGIT_W-1:0]           digits [i2ah_pkg::NUM_DIGITS];

	// ---------------------------------------------------------------- cells
	// the magnitude enters the bottom cell MSB first
	always_comb begin
		for (int j = 0; j < i2ah_pkg::BITS_PER_STEP; j++) begin
			feed[j] = mag_q[i2ah_pkg::VALUE_W-1-j];
		end
	end

	assign chain[0] = feed;

	for (genvar i = 0; i < i2ah_pkg::NUM_DIGITS; i++) begin : g_cell
		i2ah_cell u_cell (
			.clk   (clk),
			.ctl   (cell_ctl),
			.din   (chain[i]),
			.dout  (chain[i+1]),
			.digit (digits[i])
		);
	end

	// highest nonzero digit; all zero leaves index 0, which prints "0"
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < i2ah_pkg::NUM_DIGITS; i++) begin
			if (digits[i] != '0) begin
				top_idx = i2ah_pkg::DIG_IDX_W'(i);
			end
		end
	end

	// ---------------------------------------------------------------- control
	assign req_take = req_valid && !req_stall;
	assign can_load = !rsp_valid_q || !rsp_stall;
	assign abs_val  = req.value[i2ah_pkg::VALUE_W-1] ? (32'd0 - req.value) : req.value;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			i2ah_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_nxt = (req.cmd == i2ah_pkg::CMD_HEX) ? i2ah_pkg::ST_EMIT
					                                           : i2ah_pkg::ST_CONV;
				end
			end
			i2ah_pkg::ST_CONV: begin
				if (step_q == i2ah_pkg::STEP_W'(i2ah_pkg::CONV_STEPS - 1)) begin
					state_nxt = i2ah_pkg::ST_SCAN;
				end
			end
			i2ah_pkg::ST_SCAN: begin
				state_nxt = i2ah_pkg::ST_EMIT;
			end
			i2ah_pkg::ST_EMIT: begin
				if (can_load && load_rsp.last) begin
					state_nxt = i2ah_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = i2ah_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall    = 1'b1;
		load         = 1'b0;
		cell_ctl.clr = 1'b0;
		cell_ctl.en  = 1'b0;
		case (state_q)
			i2ah_pkg::ST_IDLE: begin
				req_stall    = 1'b0;
				cell_ctl.clr = req_valid;
			end
			i2ah_pkg::ST_CONV: begin
				cell_ctl.en = 1'b1;
			end
			i2ah_pkg::ST_SCAN: begin
				load = 1'b0;
			end
			i2ah_pkg::ST_EMIT: begin
				load = can_load;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	// next character
	always_comb begin
		logic [$clog2(i2ah_pkg::HEX_DIGITS)-1:0] nib_idx;
		nib_idx = $clog2(i2ah_pkg::HEX_DIGITS)'(
			i2ah_pkg::POS_W'(i2ah_pkg::HEX_LAST_POS) - pos_q);
		load_rsp.last = 1'b0;
		if (cmd_q == i2ah_pkg::CMD_HEX) begin
			if (pos_q == '0) begin
				load_rsp.char_code = i2ah_pkg::CH_ZERO;
			end else if (pos_q == i2ah_pkg::POS_W'(1)) begin
				load_rsp.char_code = i2ah_pkg::CH_X;
			end else begin
				load_rsp.char_code = i2ah_pkg::hex_char(
					mag_q[{nib_idx, 2'b00} +: i2ah_pkg::DIGIT_W]);
			end
			load_rsp.last = (pos_q == i2ah_pkg::POS_W'(i2ah_pkg::HEX_LAST_POS));
		end else if (neg_q) begin
			load_rsp.char_code = i2ah_pkg::CH_MINUS;
		end else begin
			load_rsp.char_code = i2ah_pkg::CH_ZERO + i2ah_pkg::CHAR_W'(digits[dig_q]);
			load_rsp.last = (dig_q == '0);
		end
	end

	// ---------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= i2ah_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= load_rsp;
		end
		if (req_take) begin
			cmd_q  <= req.cmd;
			neg_q  <= (req.cmd == i2ah_pkg::CMD_DEC) && req.value[i2ah_pkg::VALUE_W-1];
			mag_q  <= (req.cmd == i2ah_pkg::CMD_HEX) ? req.value : abs_val;
			step_q <= '0;
			pos_q  <= '0;
		end else begin
			if (state_q == i2ah_pkg::ST_CONV) begin
				// advance the magnitude into the chain
				mag_q  <= mag_q << i2ah_pkg::BITS_PER_STEP;
				step_q <= step_q + 1'b1;
			end
			if (state_q == i2ah_pkg::ST_SCAN) begin
				dig_q <= top_idx;
			end
			if (load) begin
				if (cmd_q == i2ah_pkg::CMD_HEX) begin
					pos_q <= pos_q + 1'b1;
				end else if (neg_q) begin
					neg_q <= 1'b0;
				end else begin
					dig_q <= dig_q - 1'b1;
				end
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ---------------------------------------------------------------- checks
	a_take_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> state_q != i2ah_pkg::ST_IDLE)
		else $error("item taken but controller stayed idle");

	a_scan_after_conv: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == i2ah_pkg::ST_SCAN |-> $past(state_q) == i2ah_pkg::ST_CONV)
		else $error("digit scan without conversion");

	a_hex_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == i2ah_pkg::ST_EMIT && cmd_q == i2ah_pkg::CMD_HEX)
		|-> pos_q <= i2ah_pkg::POS_W'(i2ah_pkg::HEX_LAST_POS))
		else $error("hex position ran past the last nibble");

	a_dec_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == i2ah_pkg::ST_EMIT && cmd_q == i2ah_pkg::CMD_DEC)
		|-> dig_q < i2ah_pkg::DIG_IDX_W'(i2ah_pkg::NUM_DIGITS))
		else $error("digit index out of range");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none

module tb_top;
	import i2ah_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int RANDOM_ITEMS = 390;
	localparam int DRAIN_WAIT   = 30;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_SPARSE,
		STALL_LONG
	} stall_style_t;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	stall_style_t stall_style = STALL_NONE;
	int           stall_run   = 0;

	rsp_t expected_chars[$];
	int   fail_count  = 0;
	int   cycle_count = 0;
	int   hex_items   = 0;
	int   dec_items   = 0;
	int   chars_seen  = 0;

	int_to_ascii_hex_dec u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d chars still due", cycle_count,
				expected_chars.size());
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// receiver back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_run <= 0;
		end else begin
			case (stall_style)
				STALL_NONE: begin
					rsp_stall <= 1'b0;
				end
				STALL_SPARSE: begin
					rsp_stall <= ($urandom_range(0, 3) == 0);
				end
				default: begin
					// hold each level for a random run
					if (stall_run == 0) begin
						rsp_stall <= ~rsp_stall;
						stall_run <= $urandom_range(1, 8);
					end else begin
						stall_run <= stall_run - 1;
					end
				end
			endcase
		end
	end

	always @(posedge clk) begin : check_char
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			chars_seen++;
			if (expected_chars.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected char %02h last %0b", rsp.char_code, rsp.last);
			end else begin
				want = expected_chars.pop_front();
				if (rsp.char_code !== want.char_code || rsp.last !== want.last) begin
					fail_count++;
					if (fail_count <= 10)
						$display("char mismatch: expected %02h last %0b, got %02h last %0b",
							want.char_code, want.last, rsp.char_code, rsp.last);
				end
			end
		end
	end

	function automatic void add_char(input logic [7:0] code);
		rsp_t c;
		c.char_code = code;
		c.last      = 1'b0;
		expected_chars.push_back(c);
	endfunction

	// queue the characters one number should produce
	function automatic void spell_number(input req_t r);
		logic [31:0] raw;
		logic [31:0] mag;
		logic [3:0]  nib;
		logic [3:0]  digs[10];
		int          nd;
		raw = r.value;
		if (r.cmd == CMD_HEX) begin
			add_char(CH_ZERO);
			add_char(CH_X);
			for (int i = 7; i >= 0; i--) begin
				nib = raw[i*4 +: 4];
				if (nib < 4'd10)
					add_char(CH_ZERO + 8'(nib));
				else
					add_char(CH_A + 8'(nib) - 8'd10);
			end
		end else if (raw == 32'd0) begin
			add_char(CH_ZERO);
		end else begin
			if (raw[31]) begin
				add_char(CH_MINUS);
				mag = 32'd0 - raw;
			end else begin
				mag = raw;
			end
			nd = 0;
			while (mag != 32'd0) begin
				digs[nd] = 4'(mag % 32'd10);
				mag      = mag / 32'd10;
				nd++;
			end
			for (int i = nd - 1; i >= 0; i--)
				add_char(CH_ZERO + 8'(digs[i]));
		end
		expected_chars[expected_chars.size() - 1].last = 1'b1;
	endfunction

	// present one number and hold it until the beat is taken
	task automatic send_number(input logic cmd, input logic [31:0] value);
		req_t r;
		r.cmd     = cmd;
		r.value   = value;
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		spell_number(r);
		if (cmd == CMD_HEX)
			hex_items++;
		else
			dec_items++;
	endtask

	// drop valid while idling, with junk on the payload
	task automatic idle_cycles(input int n);
		req_valid <= 1'b0;
		for (int i = 0; i < n; i++) begin
			req <= {1'($urandom()), 32'($urandom())};
			@(posedge clk);
		end
	endtask

	task automatic wait_all_chars();
		while (expected_chars.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		logic [31:0] p;
		case ($urandom_range(0, 5))
			0, 1: v = $urandom();
			2: v = $urandom_range(0, 99);
			3: begin
				p = 32'd1;
				repeat ($urandom_range(0, 9)) p = p * 32'd10;
				v = p + $urandom_range(0, 2) - 32'd1;
			end
			4: v = $urandom() >> $urandom_range(0, 31);
			default: begin
				case ($urandom_range(0, 4))
					0: v = 32'h0000_0000;
					1: v = 32'h7fff_ffff;
					2: v = 32'h8000_0000;
					3: v = 32'h8000_0001;
					default: v = 32'hffff_ffff;
				endcase
			end
		endcase
		if ($urandom_range(0, 1) == 1 && v != 32'h8000_0000)
			v = 32'd0 - v;
		return v;
	endfunction

	task automatic test_hex_directed();
		stall_style <= STALL_NONE;
		send_number(CMD_HEX, 32'h0000_0000);
		send_number(CMD_HEX, 32'hffff_ffff);
		send_number(CMD_HEX, 32'h7fff_ffff);
		send_number(CMD_HEX, 32'h8000_0000);
		send_number(CMD_HEX, 32'h0123_4567);
		send_number(CMD_HEX, 32'h89ab_cdef);
		idle_cycles(3);
		send_number(CMD_HEX, 32'hfedc_ba98);
		idle_cycles(1);
	endtask

	task automatic test_dec_directed();
		stall_style <= STALL_SPARSE;
		send_number(CMD_DEC, 32'd0);
		send_number(CMD_DEC, 32'd1);
		send_number(CMD_DEC, 32'hffff_ffff);
		send_number(CMD_DEC, 32'd9);
		send_number(CMD_DEC, 32'd10);
		send_number(CMD_DEC, 32'd0 - 32'd10);
		send_number(CMD_DEC, 32'h7fff_ffff);
		idle_cycles(2);
		send_number(CMD_DEC, 32'h8000_0000);
		send_number(CMD_DEC, 32'd1000000000);
		send_number(CMD_DEC, 32'd999999999);
		send_number(CMD_DEC, 32'd0 - 32'd999999999);
		send_number(CMD_DEC, 32'd12345);
		send_number(CMD_DEC, 32'd100);
		idle_cycles(1);
	endtask

	// stop sending until the output side has caught up, then resume
	task automatic test_pause_until_drained();
		stall_style <= STALL_LONG;
		for (int i = 0; i < 6; i++)
			send_number(1'($urandom()), pick_value());
		idle_cycles(1);
		wait_all_chars();
		send_number(CMD_DEC, 32'h8000_0000);
		send_number(CMD_HEX, 32'h8000_0000);
		idle_cycles(1);
	endtask

	task automatic test_random_numbers();
		int sent;
		int burst;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent % 60 == 0)
				stall_style <= stall_style_t'($urandom_range(0, 2));
			burst = $urandom_range(1, 12);
			for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
				send_number(1'($urandom()), pick_value());
				sent++;
			end
			case ($urandom_range(0, 3))
				0: ;
				1: idle_cycles($urandom_range(8, 25));
				default: idle_cycles($urandom_range(1, 6));
			endcase
		end
		idle_cycles(1);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_hex_directed();
		test_dec_directed();
		test_pause_until_drained();
		test_random_numbers();
		wait_all_chars();
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("converted %0d hex and %0d decimal numbers, %0d chars checked",
			hex_items, dec_items, chars_seen);
		$display("stall styles: none, sparse, long runs; %0d mismatches", fail_count);
		if (fail_count == 0 && expected_chars.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
